### rtl/clr_pkg.sv
// ---------------------------------------------------------------------------
// clr_pkg: shared constants for the clipped line rasterizer
// Field widths, canvas limits and register indexes.
// ---------------------------------------------------------------------------
package clr_pkg;

   localparam int CLR_COORD_BITS   = 12;
   localparam int CLR_MAX_WIDTH    = 32;
   localparam int CLR_MAX_HEIGHT   = 32;
   localparam int CLR_RESULT_LIMIT = 64;
   localparam int CLR_CNT_BITS     = $clog2(CLR_RESULT_LIMIT + 1);

   localparam int CLR_COLOR_BITS   = 32;
   localparam int CLR_XY_BITS      = 5;
   localparam int CLR_ADDR_BITS    = 10;
   localparam int CLR_SIZE_BITS    = 6;

   localparam int CSR_ADDR_BITS    = 3;
   localparam int CSR_DATA_BITS    = 32;

   localparam logic CSR_WIDTH_IDX  = 1'b0;
   localparam logic CSR_HEIGHT_IDX = 1'b1;

endpackage

### rtl/clr_if.sv
// ---------------------------------------------------------------------------
// clr_if: request and response channels of the line rasterizer
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ---------------------------------------------------------------------------
interface clr_req_if
   import clr_pkg::*;
   #(parameter int COORD_BITS = CLR_COORD_BITS)
   ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;
   logic [CLR_COLOR_BITS-1:0]    line_color;

   modport source (output valid, start_x, start_y, end_x, end_y, line_color,
                   input ready);
   modport sink   (input valid, start_x, start_y, end_x, end_y, line_color,
                   output ready);
endinterface

interface clr_rsp_if
   import clr_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic                      is_pixel;
   logic [CLR_XY_BITS-1:0]    pixel_x;
   logic [CLR_XY_BITS-1:0]    pixel_y;
   logic [CLR_ADDR_BITS-1:0]  pixel_address;
   logic [CLR_COLOR_BITS-1:0] pixel_color;
   logic                      last_item;

   modport source (output valid, is_pixel, pixel_x, pixel_y, pixel_address,
                   pixel_color, last_item, input ready);
   modport sink   (input valid, is_pixel, pixel_x, pixel_y, pixel_address,
                   pixel_color, last_item, output ready);
endinterface

### rtl/clipped_line_rasterizer_top.sv
// ---------------------------------------------------------------------------
// clipped_line_rasterizer_top: line to clipped framebuffer pixel writes
// Walks a line column by column with one shared multiply and a bit-serial
// divider, emitting pixel writes clipped to the configured canvas.
// ---------------------------------------------------------------------------
// Usage:
//   req_if carries one line request (two signed endpoints and a color).
//   rsp_if returns the pixel writes in drawing order; the final one has
//   last_item set. A request that covers no pixel returns a single marker
//   with is_pixel = 0 and last_item = 1.
//   The APB port (psel/penable/pwrite/paddr/pwdata) holds canvas_width at
//   0x0 and canvas_height at 0x4; write them only while the block is idle.
// Sequencing:
//   One request at a time; req_if.ready is high only when idle. After setup
//   a sloped line needs one signed divide for the y intercept, one for the
//   top of the first column and one per column, each run on the shared
//   multiply and the bit-serial divider; the pixel writes of each column
//   follow its divide, and a final step closes the request.
// Reset clears the canvas to 32 x 32 and drops any request in flight.
// A stalled rsp_if holds the pending write; the block waits on the next one.
// ---------------------------------------------------------------------------
module clipped_line_rasterizer_top
   import clr_pkg::*;
   #(parameter int COORD_BITS = CLR_COORD_BITS)
   (
   input  logic                     clock,
   input  logic                     reset,
   clr_req_if.sink                  req_if,
   clr_rsp_if.source                rsp_if,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
   );

   localparam int MW  = COORD_BITS + 1;
   localparam int PRW = 2 * MW;
   localparam int PW  = 2 * COORD_BITS - 1;
   localparam int QW  = 2 * COORD_BITS;
   localparam int CW  = 2 * COORD_BITS + 1;
   localparam int YW  = 2 * COORD_BITS + 2;
   localparam int DCW = $clog2(PW);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SETUP = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_LOAD  = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_POST  = 3'd5;
   localparam logic [2:0] S_ROWS  = 3'd6;
   localparam logic [2:0] S_FLUSH = 3'd7;

   localparam logic [1:0] PH_C = 2'd0;
   localparam logic [1:0] PH_A = 2'd1;
   localparam logic [1:0] PH_B = 2'd2;

   // config
   logic [CLR_SIZE_BITS-1:0] canvas_width_ff, canvas_width_in;
   logic [CLR_SIZE_BITS-1:0] canvas_height_ff, canvas_height_in;
   logic [CLR_SIZE_BITS-1:0] w_eff, h_eff;

   // control
   logic [2:0]              state_ff, state_in;
   logic [1:0]              phase_ff, phase_in;
   logic [DCW-1:0]          dcnt_ff, dcnt_in;
   logic                    held_valid_ff, held_valid_in;
   logic [CLR_CNT_BITS-1:0] count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // request payload
   logic signed [COORD_BITS-1:0] x1_ff, x1_in, y1_ff, y1_in;
   logic signed [COORD_BITS-1:0] x2_ff, x2_in, y2_ff, y2_in;
   logic [CLR_COLOR_BITS-1:0]    color_ff, color_in;

   // datapath
   logic signed [MW-1:0]    dx_ff, dx_in, dy_ff, dy_in;
   logic signed [MW-1:0]    mul_x_ff, mul_x_in;
   logic signed [PRW-1:0]   prod_ff, prod_in;
   logic [PW-1:0]           num_ff, num_in;
   logic [COORD_BITS-1:0]   rem_ff, rem_in, div_ff, div_in;
   logic                    neg_ff, neg_in;
   logic signed [CW-1:0]    c_ff, c_in;
   logic signed [YW-1:0]    a_ff, a_in;
   logic [CLR_XY_BITS-1:0]  col_ff, col_in, col_end_ff, col_end_in;
   logic [CLR_XY_BITS-1:0]  row_ff, row_in, row_end_ff, row_end_in;
   logic                    vert_ff, vert_in;
   logic [CLR_XY_BITS-1:0]  held_x_ff, held_x_in, held_y_ff, held_y_in;
   logic [CLR_ADDR_BITS-1:0] held_addr_ff, held_addr_in;

   // response register
   logic                      rsp_pix_ff, rsp_pix_in;
   logic [CLR_XY_BITS-1:0]    rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [CLR_ADDR_BITS-1:0]  rsp_addr_ff, rsp_addr_in;
   logic [CLR_COLOR_BITS-1:0] rsp_color_ff, rsp_color_in;
   logic                      rsp_last_ff, rsp_last_in;

   // combinational helpers
   logic signed [MW-1:0]     w_m1;
   logic signed [YW-1:0]     h_m1;
   logic signed [COORD_BITS-1:0] x_lo, x_hi, y_lo, y_hi;
   logic signed [MW-1:0]     col_start, col_last;
   logic                     x1_visible;
   logic [PRW-1:0]           prod_mag;
   logic [MW-1:0]            dx_mag;
   logic [COORD_BITS+1:0]    trial;
   logic                     trial_ge;
   logic signed [QW-1:0]     quo;
   logic signed [YW-1:0]     b_val;
   logic signed [YW-1:0]     clip_lo, clip_hi, lo_c, hi_c;
   logic                     clip_empty;
   logic [10:0]              addr_full;
   logic                     out_free;
   logic                     csr_write;

   // ------------------------------------------------------------------------
   // configuration
   // ------------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign prdata    = (paddr[2] == CSR_HEIGHT_IDX) ? CSR_DATA_BITS'(canvas_height_ff)
                                                   : CSR_DATA_BITS'(canvas_width_ff);

   always_comb begin
      canvas_width_in  = canvas_width_ff;
      canvas_height_in = canvas_height_ff;
      if (csr_write) begin
         unique case (paddr[2])
            CSR_WIDTH_IDX:  canvas_width_in  = pwdata[CLR_SIZE_BITS-1:0];
            CSR_HEIGHT_IDX: canvas_height_in = pwdata[CLR_SIZE_BITS-1:0];
         endcase
      end
   end

   assign w_eff = (canvas_width_ff > CLR_SIZE_BITS'(CLR_MAX_WIDTH))
                  ? CLR_SIZE_BITS'(CLR_MAX_WIDTH) : canvas_width_ff;
   assign h_eff = (canvas_height_ff > CLR_SIZE_BITS'(CLR_MAX_HEIGHT))
                  ? CLR_SIZE_BITS'(CLR_MAX_HEIGHT) : canvas_height_ff;

   assign w_m1 = $signed(MW'(w_eff)) - $signed(MW'(1));
   assign h_m1 = $signed(YW'(h_eff)) - $signed(YW'(1));

   // ------------------------------------------------------------------------
   // shared datapath pieces
   // ------------------------------------------------------------------------
   assign x_lo = (x1_ff < x2_ff) ? x1_ff : x2_ff;
   assign x_hi = (x1_ff < x2_ff) ? x2_ff : x1_ff;
   assign y_lo = (y1_ff < y2_ff) ? y1_ff : y2_ff;
   assign y_hi = (y1_ff < y2_ff) ? y2_ff : y1_ff;

   assign col_start  = x_lo[COORD_BITS-1] ? '0 : MW'(x_lo);
   assign col_last   = (MW'(x_hi) > w_m1) ? w_m1 : MW'(x_hi);
   assign x1_visible = !x1_ff[COORD_BITS-1] && (MW'(x1_ff) <= w_m1);

   assign prod_mag = prod_ff[PRW-1] ? PRW'(-prod_ff) : PRW'(prod_ff);
   assign dx_mag   = dx_ff[MW-1] ? MW'(-dx_ff) : MW'(dx_ff);

   // restoring divider step
   assign trial    = {1'b0, rem_ff, num_ff[PW-1]} - {2'b00, div_ff};
   assign trial_ge = !trial[COORD_BITS+1];

   assign quo   = neg_ff ? -$signed(QW'(num_ff)) : $signed(QW'(num_ff));
   assign b_val = YW'(quo) + YW'(c_ff);

   // row span clip, shared by the vertical case and every column
   always_comb begin
      if (state_ff == S_SETUP) begin
         clip_lo = YW'(y_lo);
         clip_hi = YW'(y_hi);
      end else begin
         clip_lo = (a_ff < b_val) ? a_ff : b_val;
         clip_hi = (a_ff < b_val) ? b_val : a_ff;
      end
   end

   assign lo_c       = clip_lo[YW-1] ? '0 : clip_lo;
   assign hi_c       = (clip_hi > h_m1) ? h_m1 : clip_hi;
   assign clip_empty = lo_c > hi_c;

   assign addr_full = 11'(row_ff) * 11'(w_eff) + 11'(col_ff);
   assign out_free  = !rsp_valid_ff || rsp_if.ready;

   // ------------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      dcnt_in       = dcnt_ff;
      held_valid_in = held_valid_ff;
      count_in      = count_ff;
      x1_in         = x1_ff;
      y1_in         = y1_ff;
      x2_in         = x2_ff;
      y2_in         = y2_ff;
      color_in      = color_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      mul_x_in      = mul_x_ff;
      prod_in       = prod_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      neg_in        = neg_ff;
      c_in          = c_ff;
      a_in          = a_ff;
      col_in        = col_ff;
      col_end_in    = col_end_ff;
      row_in        = row_ff;
      row_end_in    = row_end_ff;
      vert_in       = vert_ff;
      held_x_in     = held_x_ff;
      held_y_in     = held_y_ff;
      held_addr_in  = held_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_pix_in    = rsp_pix_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_color_in  = rsp_color_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               x1_in    = req_if.start_x;
               y1_in    = req_if.start_y;
               x2_in    = req_if.end_x;
               y2_in    = req_if.end_y;
               color_in = req_if.line_color;
               state_in = S_SETUP;
            end
         end

         S_SETUP: begin
            dx_in = MW'(x1_ff) - MW'(x2_ff);
            dy_in = MW'(y1_ff) - MW'(y2_ff);
            if (x1_ff == x2_ff) begin
               vert_in = 1'b1;
               col_in  = x1_ff[CLR_XY_BITS-1:0];
               if (x1_visible && !clip_empty) begin
                  row_in     = lo_c[CLR_XY_BITS-1:0];
                  row_end_in = hi_c[CLR_XY_BITS-1:0];
                  state_in   = S_ROWS;
               end else begin
                  state_in = S_FLUSH;
               end
            end else begin
               vert_in    = 1'b0;
               col_in     = col_start[CLR_XY_BITS-1:0];
               col_end_in = col_last[CLR_XY_BITS-1:0];
               mul_x_in   = MW'(x1_ff);
               phase_in   = PH_C;
               if (col_start > col_last) begin
                  state_in = S_FLUSH;
               end else begin
                  state_in = S_MUL;
               end
            end
         end

         S_MUL: begin
            prod_in  = PRW'(dy_ff) * PRW'(mul_x_ff);
            state_in = S_LOAD;
         end

         S_LOAD: begin
            num_in   = prod_mag[PW-1:0];
            rem_in   = '0;
            div_in   = dx_mag[COORD_BITS-1:0];
            neg_in   = prod_ff[PRW-1] ^ dx_ff[MW-1];
            dcnt_in  = '0;
            state_in = S_DIV;
         end

         S_DIV: begin
            num_in  = {num_ff[PW-2:0], trial_ge};
            rem_in  = trial_ge ? trial[COORD_BITS-1:0]
                               : {rem_ff[COORD_BITS-2:0], num_ff[PW-1]};
            dcnt_in = dcnt_ff + DCW'(1);
            if (dcnt_ff == DCW'(PW - 1)) begin
               state_in = S_POST;
            end
         end

         S_POST: begin
            unique case (phase_ff)
               PH_C: begin
                  c_in     = CW'(y1_ff) - CW'(quo);
                  mul_x_in = MW'(col_ff);
                  phase_in = PH_A;
                  state_in = S_MUL;
               end
               PH_A: begin
                  a_in     = b_val;
                  mul_x_in = $signed(MW'(col_ff)) + $signed(MW'(1));
                  phase_in = PH_B;
                  state_in = S_MUL;
               end
               default: begin
                  a_in = b_val;
                  if (!clip_empty) begin
                     row_in     = lo_c[CLR_XY_BITS-1:0];
                     row_end_in = hi_c[CLR_XY_BITS-1:0];
                     state_in   = S_ROWS;
                  end else if (col_ff == col_end_ff) begin
                     state_in = S_FLUSH;
                  end else begin
                     col_in   = col_ff + CLR_XY_BITS'(1);
                     mul_x_in = $signed(MW'(col_ff)) + $signed(MW'(2));
                     state_in = S_MUL;
                  end
               end
            endcase
         end

         S_ROWS: begin
            if (!held_valid_ff || out_free) begin
               if (held_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_pix_in   = 1'b1;
                  rsp_x_in     = held_x_ff;
                  rsp_y_in     = held_y_ff;
                  rsp_addr_in  = held_addr_ff;
                  rsp_color_in = color_ff;
                  rsp_last_in  = 1'b0;
               end
               held_valid_in = 1'b1;
               held_x_in     = col_ff;
               held_y_in     = row_ff;
               held_addr_in  = addr_full[CLR_ADDR_BITS-1:0];
               count_in      = count_ff + CLR_CNT_BITS'(1);
               if (count_ff == CLR_CNT_BITS'(CLR_RESULT_LIMIT - 1)) begin
                  state_in = S_FLUSH;
               end else if (row_ff != row_end_ff) begin
                  row_in = row_ff + CLR_XY_BITS'(1);
               end else if (vert_ff || (col_ff == col_end_ff)) begin
                  state_in = S_FLUSH;
               end else begin
                  col_in   = col_ff + CLR_XY_BITS'(1);
                  mul_x_in = $signed(MW'(col_ff)) + $signed(MW'(2));
                  phase_in = PH_B;
                  state_in = S_MUL;
               end
            end
         end

         S_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               if (held_valid_ff) begin
                  rsp_pix_in   = 1'b1;
                  rsp_x_in     = held_x_ff;
                  rsp_y_in     = held_y_ff;
                  rsp_addr_in  = held_addr_ff;
                  rsp_color_in = color_ff;
               end else begin
                  rsp_pix_in   = 1'b0;
                  rsp_x_in     = '0;
                  rsp_y_in     = '0;
                  rsp_addr_in  = '0;
                  rsp_color_in = '0;
               end
               held_valid_in = 1'b0;
               count_in      = '0;
               state_in      = S_IDLE;
            end
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         canvas_width_ff  <= CLR_SIZE_BITS'(CLR_MAX_WIDTH);
         canvas_height_ff <= CLR_SIZE_BITS'(CLR_MAX_HEIGHT);
         state_ff         <= S_IDLE;
         phase_ff         <= PH_C;
         dcnt_ff          <= '0;
         held_valid_ff    <= 1'b0;
         count_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         canvas_width_ff  <= canvas_width_in;
         canvas_height_ff <= canvas_height_in;
         state_ff         <= state_in;
         phase_ff         <= phase_in;
         dcnt_ff          <= dcnt_in;
         held_valid_ff    <= held_valid_in;
         count_ff         <= count_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x1_ff        <= x1_in;
      y1_ff        <= y1_in;
      x2_ff        <= x2_in;
      y2_ff        <= y2_in;
      color_ff     <= color_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      mul_x_ff     <= mul_x_in;
      prod_ff      <= prod_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      div_ff       <= div_in;
      neg_ff       <= neg_in;
      c_ff         <= c_in;
      a_ff         <= a_in;
      col_ff       <= col_in;
      col_end_ff   <= col_end_in;
      row_ff       <= row_in;
      row_end_ff   <= row_end_in;
      vert_ff      <= vert_in;
      held_x_ff    <= held_x_in;
      held_y_ff    <= held_y_in;
      held_addr_ff <= held_addr_in;
      rsp_pix_ff   <= rsp_pix_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // ------------------------------------------------------------------------
   // ports
   // ------------------------------------------------------------------------
   assign req_if.ready = (state_ff == S_IDLE);

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.is_pixel      = rsp_pix_ff;
   assign rsp_if.pixel_x       = rsp_x_ff;
   assign rsp_if.pixel_y       = rsp_y_ff;
   assign rsp_if.pixel_address = rsp_addr_ff;
   assign rsp_if.pixel_color   = rsp_color_ff;
   assign rsp_if.last_item     = rsp_last_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_marker_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_pix_ff) |-> rsp_last_ff)
      else $error("marker response without last_item");

   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < div_ff))
      else $error("divider remainder not below divisor");

   a_row_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROWS) |-> (row_ff <= row_end_ff))
      else $error("row walk past end of span");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CLR_CNT_BITS'(CLR_RESULT_LIMIT))
      else $error("pixel count beyond limit");

   a_idle_no_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !held_valid_ff)
      else $error("pending pixel left over in idle");

endmodule
